@@ design/wfsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsa_pkg
// shared types and constants of the worst-fit segment allocator
// ----------------------------------------------------------------------------
package wfsa_pkg;

    localparam int NUM_SEGMENTS_DEF = 16;
    localparam int SIZE_BITS_DEF    = 16;
    localparam int OWNER_BITS_DEF   = 8;

    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 4;
    localparam int SIZE_W   = 16;
    localparam int PID_W    = 8;
    localparam int REQ_W    = 16;
    localparam int GRANT_W  = 1;
    localparam int CHOSEN_W = 4;

    localparam int S_DATA_BITS = INDEX_W + SIZE_W + PID_W + REQ_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((CHOSEN_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

    typedef struct packed {
        logic load_en;
        logic scan_start;
        logic scan_step;
        logic commit;
    } wfsa_cmd_t;

    typedef struct packed {
        logic scan_last;
    } wfsa_status_t;

endpackage : wfsa_pkg
`default_nettype wire

@@ design/wfsa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module wfsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule : wfsa_ram
`default_nettype wire

@@ design/wfsa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsa_datapath
// segment table, scan pointer, best-candidate tracking and result register
// ----------------------------------------------------------------------------
module wfsa_datapath #(
    parameter int NUM_SEGMENTS = wfsa_pkg::NUM_SEGMENTS_DEF,
    parameter int SIZE_BITS    = wfsa_pkg::SIZE_BITS_DEF,
    parameter int OWNER_BITS   = wfsa_pkg::OWNER_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire wfsa_pkg::wfsa_cmd_t             cmd,
    output wfsa_pkg::wfsa_status_t               status,
    input  wire logic [wfsa_pkg::INDEX_W-1:0]    in_index,
    input  wire logic [wfsa_pkg::SIZE_W-1:0]     in_size,
    input  wire logic [wfsa_pkg::PID_W-1:0]      in_pid,
    input  wire logic [wfsa_pkg::REQ_W-1:0]      in_req,
    output logic      [wfsa_pkg::GRANT_W-1:0]    granted,
    output logic      [wfsa_pkg::CHOSEN_W-1:0]   chosen_segment,
    output logic      [OWNER_BITS-1:0]           owner_wdata,
    output logic      [OWNER_BITS-1:0]           owner_rdata
);

    import wfsa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SEGMENTS);

    logic [NUM_SEGMENTS-1:0] present_reg;
    logic [NUM_SEGMENTS-1:0] taken_reg;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic [SIZE_BITS-1:0]  req_reg;
    logic [OWNER_BITS-1:0] pid_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0]  best_size_reg;
    logic                  granted_reg;
    logic [CHOSEN_W-1:0]   chosen_reg;

    logic                  load_hit;
    logic [IDX_W-1:0]      load_idx;
    logic [SIZE_BITS-1:0]  size_rd;
    logic                  hit;
    logic                  better;
    logic                  owner_we;

    assign load_idx = IDX_W'(in_index);
    assign load_hit = cmd.load_en && (32'(in_index) < 32'(NUM_SEGMENTS));

    wfsa_ram #(
        .WIDTH(SIZE_BITS),
        .DEPTH(NUM_SEGMENTS)
    ) u_size_ram (
        .aclk (aclk),
        .we   (load_hit),
        .waddr(load_idx),
        .wdata(SIZE_BITS'(in_size)),
        .raddr(scan_idx_reg),
        .rdata(size_rd)
    );

    assign owner_we    = cmd.commit && found_reg;
    assign owner_wdata = pid_reg;

    wfsa_ram #(
        .WIDTH(OWNER_BITS),
        .DEPTH(NUM_SEGMENTS)
    ) u_owner_ram (
        .aclk (aclk),
        .we   (owner_we),
        .waddr(best_idx_reg),
        .wdata(pid_reg),
        .raddr(best_idx_reg),
        .rdata(owner_rdata)
    );

    assign hit    = cmp_vld_reg && present_reg[cmp_idx_reg] && !taken_reg[cmp_idx_reg]
                    && (size_rd >= req_reg);
    assign better = hit && (!found_reg || (size_rd > best_size_reg));

    assign status.scan_last = (scan_idx_reg == IDX_W'(NUM_SEGMENTS - 1));

    // segment flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            taken_reg   <= '0;
        end else begin
            if (load_hit) begin
                present_reg[load_idx] <= 1'b1;
                taken_reg[load_idx]   <= 1'b0;
            end
            if (owner_we) begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.scan_step;
        end
    end

    // scan and best candidate
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            req_reg      <= SIZE_BITS'(in_req);
            pid_reg      <= OWNER_BITS'(in_pid);
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end else begin
            if (cmd.scan_step && !status.scan_last) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (better) begin
                found_reg     <= 1'b1;
                best_idx_reg  <= cmp_idx_reg;
                best_size_reg <= size_rd;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? CHOSEN_W'(best_idx_reg) : '0;
        end
    end

    assign granted        = granted_reg;
    assign chosen_segment = chosen_reg;

endmodule : wfsa_datapath
`default_nettype wire

@@ design/wfsa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsa_ctrl
// request sequencer: accept, scan, drain, result hand-off
// ----------------------------------------------------------------------------
module wfsa_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wfsa_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output wfsa_pkg::wfsa_cmd_t                 cmd,
    input  wire wfsa_pkg::wfsa_status_t         status
);

    import wfsa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;
    logic       fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign cmd.load_en    = accept && (in_opcode == OP_LOAD);
    assign cmd.scan_start = accept && (in_opcode == OP_ALLOC);
    assign cmd.scan_step  = (state_reg == ST_SCAN);
    assign cmd.commit     = fire;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.scan_start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule : wfsa_ctrl
`default_nettype wire

@@ design/worst_fit_segment_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// worst_fit_segment_allocator_unit
// worst-fit allocator over a table of memory segments
// ----------------------------------------------------------------------------
// s_ channel carries one request per handshake: s_tuser is the opcode
// (load a segment size or allocate), s_tdata the index, size, owner id
// and requested size. a load gives no result. an allocate reads the
// table entries in turn on the size ram read port, then does the last
// compare in a drain state and the write-back to the result register;
// the request fields are captured at acceptance. the next request is
// taken only once the result has entered the output register, so a
// new request is not accepted while an allocate is still in progress.
// m_ channel gives granted on m_tuser and the chosen index on m_tdata.
// a result waits in the output register while m_tready is low; a
// following allocate then holds in write-back until the register frees.
// reset clears the present and taken flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module worst_fit_segment_allocator_unit #(
    parameter int NUM_SEGMENTS = wfsa_pkg::NUM_SEGMENTS_DEF,
    parameter int SIZE_BITS    = wfsa_pkg::SIZE_BITS_DEF,
    parameter int OWNER_BITS   = wfsa_pkg::OWNER_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // segment_index, segment_size, process_id, request_size
    input  wire logic [wfsa_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  wire logic [wfsa_pkg::OPCODE_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // chosen_segment
    output logic      [wfsa_pkg::M_TDATA_W-1:0]   m_tdata,
    // granted
    output logic      [wfsa_pkg::GRANT_W-1:0]     m_tuser
);

    import wfsa_pkg::*;

    localparam int IDX_LSB  = 0;
    localparam int SIZE_LSB = IDX_LSB + INDEX_W;
    localparam int PID_LSB  = SIZE_LSB + SIZE_W;
    localparam int REQ_LSB  = PID_LSB + PID_W;

    wfsa_cmd_t             cmd;
    wfsa_status_t          status;
    logic [CHOSEN_W-1:0]   chosen;
    logic [OWNER_BITS-1:0] owner_wdata;
    logic [OWNER_BITS-1:0] owner_rdata;

    wfsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_opcode(s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    wfsa_datapath #(
        .NUM_SEGMENTS(NUM_SEGMENTS),
        .SIZE_BITS   (SIZE_BITS),
        .OWNER_BITS  (OWNER_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_index      (s_tdata[IDX_LSB +: INDEX_W]),
        .in_size       (s_tdata[SIZE_LSB +: SIZE_W]),
        .in_pid        (s_tdata[PID_LSB +: PID_W]),
        .in_req        (s_tdata[REQ_LSB +: REQ_W]),
        .granted       (m_tuser),
        .chosen_segment(chosen),
        .owner_wdata   (owner_wdata),
        .owner_rdata   (owner_rdata)
    );

    assign m_tdata = M_TDATA_W'(chosen);

    a_result_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result raised without a commit");

    a_no_accept_in_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s_tready)
        else $error("request accepted during result write-back");

    a_owner_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.commit, 2) && $past(m_tuser, 1) == GRANT_W'(1))
        |-> owner_rdata == $past(owner_wdata, 2))
        else $error("owner id not recorded in granted segment");

endmodule : worst_fit_segment_allocator_unit
`default_nettype wire

@@ tb/tb_worst_fit_segment_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worst_fit_segment_allocator_unit
// checks grants and refusals of the worst-fit segment allocator
// ----------------------------------------------------------------------------
// a shadow segment table predicts each allocate request: the largest
// present, free segment that covers the requested size, lowest index on
// ties. directed cases cover the empty table, zero sizes, ties, reloads
// and the field extremes; random traffic mixes load bursts and allocate
// requests sized against the live table, under three stall profiles and
// one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_worst_fit_segment_allocator_unit;
    import wfsa_pkg::*;

    localparam int NSEG        = NUM_SEGMENTS_DEF;
    localparam int STALL_LEN   = 300;
    localparam int SETTLE      = 3 * (NSEG + 3);
    localparam int DRAIN_LIMIT = 50000;

    typedef struct {
        logic       granted;
        logic [3:0] segment;
    } grant_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic [OPCODE_W-1:0]     s_tuser  = OP_LOAD;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [GRANT_W-1:0]      m_tuser;

    logic [15:0] tbl_size    [NSEG];
    logic        tbl_present [NSEG];
    logic        tbl_taken   [NSEG];
    grant_t      pending_grants[$];

    int  error_count   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic long_stall   = 1'b0;
    int  stall_cnt     = 0;

    worst_fit_segment_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic void predict_request(input logic [OPCODE_W-1:0] op,
                                            input logic [3:0] idx,
                                            input logic [15:0] size,
                                            input logic [15:0] req);
        grant_t      g;
        logic        found;
        logic [15:0] best_size;
        g.granted = 1'b0;
        g.segment = 4'd0;
        found     = 1'b0;
        best_size = '0;
        if (op == OP_LOAD) begin
            tbl_size[idx]    = size;
            tbl_present[idx] = 1'b1;
            tbl_taken[idx]   = 1'b0;
            return;
        end
        for (int i = 0; i < NSEG; i++) begin
            if (tbl_present[i] && !tbl_taken[i] && tbl_size[i] >= req &&
                (!found || tbl_size[i] > best_size)) begin
                found     = 1'b1;
                best_size = tbl_size[i];
                g.segment = i[3:0];
            end
        end
        if (found) begin
            tbl_taken[g.segment] = 1'b1;
            g.granted = 1'b1;
        end
        pending_grants.push_back(g);
    endfunction

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [3:0] idx,
                                input logic [15:0] size, input logic [7:0] pid,
                                input logic [15:0] req);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - S_DATA_BITS){1'b0}}, req, pid, size, idx};
        do @(posedge aclk); while (!s_tready);
        predict_request(op, idx, size, req);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 7));
            2:       return 16'hFFFF - 16'($urandom_range(0, 2));
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: random stalls, long hold-off on demand, check
    always @(posedge aclk) begin
        grant_t g;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t unexpected result: granted=%0d segment=%0d",
                             $realtime, m_tuser[0], m_tdata[CHOSEN_W-1:0]);
            end else begin
                g = pending_grants.pop_front();
                if (m_tuser[0] !== g.granted || m_tdata[CHOSEN_W-1:0] !== g.segment) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t mismatch: expected granted=%0d segment=%0d, got granted=%0d segment=%0d",
                                 $realtime, g.granted, g.segment, m_tuser[0],
                                 m_tdata[CHOSEN_W-1:0]);
                end
            end
        end
        if (long_stall && stall_cnt < STALL_LEN) begin
            m_tready  <= 1'b0;
            stall_cnt <= stall_cnt + 1;
        end else begin
            if (!long_stall)
                stall_cnt <= 0;
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic test_directed_cases();
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0000);   // empty table
        send_request(OP_LOAD,  4'd0, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h01, 16'h0000);   // zero size fits zero
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h02, 16'h0000);   // only segment taken
        send_request(OP_LOAD,  4'd15, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_request(OP_LOAD,  4'd7,  16'hFFFF, 8'h00, 16'h0000);
        send_request(OP_LOAD,  4'd3,  16'h0100, 8'h00, 16'h0000);
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'hFF, 16'hFFFF);   // tie, lowest index
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h80, 16'hFFFF);
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h7F, 16'hFFFF);   // refused
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h10, 16'h0101);   // refused by one
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0100);   // exact fit
        send_request(OP_LOAD,  4'd7,  16'h8000, 8'h00, 16'h0000);  // reload a taken one
        send_request(OP_ALLOC, 4'hA, 16'hFFFF, 8'h55, 16'h0001);
        send_request(OP_LOAD,  4'd15, 16'h0005, 8'hAA, 16'hAAAA);
        send_request(OP_LOAD,  4'd1,  16'h0005, 8'h55, 16'h5555);
        send_request(OP_LOAD,  4'd9,  16'h5555, 8'h00, 16'h0000);
        send_request(OP_LOAD,  4'd6,  16'hAAAA, 8'h00, 16'h0000);
        send_request(OP_ALLOC, 4'd5, 16'h5555, 8'hAA, 16'hAAAB);   // refused
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0006);   // largest first
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0006);
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0005);   // equal sizes
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0005);
        send_request(OP_ALLOC, 4'd0, 16'h0000, 8'h00, 16'h0000);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        for (int i = 0; i < 8; i++)
            send_request(OP_LOAD, 4'(i), pick_size(), 8'($urandom), 16'($urandom));
        long_stall <= 1'b1;
        repeat (12)
            send_request(OP_ALLOC, 4'($urandom), 16'($urandom), 8'($urandom),
                         16'($urandom_range(0, 300)));
        long_stall <= 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        int          sent;
        int          j;
        logic [15:0] req;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(2, 8)) begin
                    send_request(OP_LOAD, 4'($urandom), pick_size(), 8'($urandom),
                                 16'($urandom));
                    sent++;
                end
            end else if ($urandom_range(0, 99) < 35) begin
                send_request(OP_LOAD, 4'($urandom), pick_size(), 8'($urandom),
                             16'($urandom));
                sent++;
            end else begin
                j = $urandom_range(0, NSEG - 1);
                case ($urandom_range(0, 4))
                    0:       req = tbl_size[j];
                    1:       req = tbl_size[j] + 16'd1;
                    2:       req = 16'h0000;
                    default: req = pick_size();
                endcase
                send_request(OP_ALLOC, 4'($urandom), 16'($urandom), 8'($urandom), req);
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NSEG; i++) begin
            tbl_size[i]    = '0;
            tbl_present[i] = 1'b0;
            tbl_taken[i]   = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();

        send_idle_pct = 30;
        recv_idle_pct <= 87;
        test_random_traffic(260);

        send_idle_pct = 87;
        recv_idle_pct <= 30;
        test_random_traffic(260);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_output_backpressure();
        test_random_traffic(260);

        drain_results();
        error_count += pending_grants.size();
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(64'd2_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
design/wfsa_pkg.sv
design/wfsa_ram.sv
design/wfsa_datapath.sv
design/wfsa_ctrl.sv
design/worst_fit_segment_allocator_unit.sv
tb/tb_worst_fit_segment_allocator_unit.sv
